FILE: hdl/nfpa_pkg.sv
// ----------------------------------------------------------------------------
// nfpa_pkg
// Shared types, constants and helper functions of the nearest free point
// allocator: coordinate and point types, command and status codes, the scan
// pipeline tags and the controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package nfpa_pkg;

  localparam int CAPACITY    = 64;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int COUNT_OUT_W = 7;

  localparam int CRD_W  = 20;
  localparam int MAG_W  = CRD_W + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int DIST_W = SQ_W + 2;
  localparam int THR_W  = 32;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = THR_W;

  localparam logic [CFG_IDX_W-1:0] CFG_GROUND_OFFSET  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEDUPE_DIST_SQ = 1'b1;

  localparam logic [THR_W-1:0] DEDUPE_RESET = 32'd2621;

  // The distance unit has three register stages; the last result passes the
  // memory read and all three of them after the scan stops issuing.
  localparam int DIST_LAT  = 3;
  localparam int DRAIN_LEN = DIST_LAT;
  localparam int DRAIN_W   = $clog2(DRAIN_LEN);

  typedef logic signed [CRD_W-1:0] crd_t;
  typedef logic        [MAG_W-1:0] mag_t;

  localparam crd_t CRD_MAX = 20'sh7FFFF;
  localparam crd_t CRD_MIN = 20'sh80000;

  typedef struct packed {
    crd_t x;
    crd_t y;
    crd_t z;
  } point_t;

  // One table entry as held in the point memory: the taken mark and the point.
  typedef struct packed {
    logic   tk;
    point_t pt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_CLAIM   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_DUP  = 2'd1,
    STS_FULL = 2'd2,
    STS_NONE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
    logic             tk;
  } scan_tag_t;

  typedef struct packed {
    scan_tag_t         tag;
    logic              eq;
    point_t            pt;
    logic [DIST_W-1:0] dsq;
  } scan_res_t;

  function automatic crd_t sat_add(crd_t a, crd_t b);
    logic signed [CRD_W:0] s;
    s = {a[CRD_W-1], a} + {b[CRD_W-1], b};
    if (s[CRD_W] != s[CRD_W-1]) begin
      return s[CRD_W] ? CRD_MIN : CRD_MAX;
    end
    return s[CRD_W-1:0];
  endfunction

  function automatic mag_t abs_diff(crd_t a, crd_t b);
    logic signed [MAG_W-1:0] d;
    d = {a[CRD_W-1], a} - {b[CRD_W-1], b};
    return d[MAG_W-1] ? mag_t'(-d) : mag_t'(d);
  endfunction

  function automatic logic [COUNT_OUT_W-1:0] count_out(logic [CNT_W-1:0] c);
    logic [CNT_W+COUNT_OUT_W-1:0] w;
    w = {{COUNT_OUT_W{1'b0}}, c};
    return w[COUNT_OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/nfpa_ram.sv
// ----------------------------------------------------------------------------
// nfpa_ram
// Generic simple dual-port RAM: one write port and one read port, with the
// read data registered and shown in the cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none

module nfpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/nfpa_dist.sv
// ----------------------------------------------------------------------------
// nfpa_dist
// Three-stage squared distance unit. Stage one takes the absolute axis
// differences and the exact match, stage two squares them, stage three sums
// the squares. The scan tag and the point travel alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module nfpa_dist import nfpa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire scan_tag_t in_tag,
  input  wire point_t    in_pt,
  input  wire point_t    query,
  output scan_res_t      res
);

  scan_tag_t         s1_tag_r, s2_tag_r, s3_tag_r;
  logic              s1_eq_r, s2_eq_r, s3_eq_r;
  point_t            s1_pt_r, s2_pt_r, s3_pt_r;
  mag_t              ax_r, ay_r, az_r;
  logic [SQ_W-1:0]   sx_r, sy_r, sz_r;
  logic [DIST_W-1:0] dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r.vld <= 1'b0;
      s2_tag_r.vld <= 1'b0;
      s3_tag_r.vld <= 1'b0;
    end else begin
      s1_tag_r.vld <= in_tag.vld;
      s2_tag_r.vld <= s1_tag_r.vld;
      s3_tag_r.vld <= s2_tag_r.vld;
    end

    s1_tag_r.idx <= in_tag.idx;
    s1_tag_r.tk  <= in_tag.tk;
    s1_pt_r      <= in_pt;
    s1_eq_r      <= (in_pt == query);
    ax_r         <= abs_diff(in_pt.x, query.x);
    ay_r         <= abs_diff(in_pt.y, query.y);
    az_r         <= abs_diff(in_pt.z, query.z);

    s2_tag_r.idx <= s1_tag_r.idx;
    s2_tag_r.tk  <= s1_tag_r.tk;
    s2_pt_r      <= s1_pt_r;
    s2_eq_r      <= s1_eq_r;
    sx_r         <= ax_r * ax_r;
    sy_r         <= ay_r * ay_r;
    sz_r         <= az_r * az_r;

    s3_tag_r.idx <= s2_tag_r.idx;
    s3_tag_r.tk  <= s2_tag_r.tk;
    s3_pt_r      <= s2_pt_r;
    s3_eq_r      <= s2_eq_r;
    dist_r       <= {{(DIST_W-SQ_W){1'b0}}, sx_r} + {{(DIST_W-SQ_W){1'b0}}, sy_r}
                  + {{(DIST_W-SQ_W){1'b0}}, sz_r};
  end

  assign res.tag = s3_tag_r;
  assign res.eq  = s3_eq_r;
  assign res.pt  = s3_pt_r;
  assign res.dsq = dist_r;

endmodule

`default_nettype wire

FILE: hdl/nearest_free_point_allocator.sv
// ----------------------------------------------------------------------------
// nearest_free_point_allocator
// Table of 3D points in signed Q12.8. Insert drops near duplicates, claim
// hands out and marks the nearest free point, release frees the first exact
// match and clear empties the table. Points live in one synchronous RAM that
// is scanned one entry per cycle through a pipelined squared distance unit.
//
//   channel  ports                                   handshake
//   input    in_cmd, in_pos_x/y/z                    start while busy is low
//   result   out_found, out_x/y/z, out_status,       out_valid for one cycle
//            out_point_count
//   config   cfg_index, cfg_data                     cfg_we, no wait
//
// An item keeps the block busy through one memory read per stored point,
// the drain of the three stages of the distance unit and the write-back.
// The result word shows in the same cycle as busy falls, when the next
// command may already start. Reset is synchronous and empties the table
// at once. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_free_point_allocator import nfpa_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [1:0]             in_cmd,
  input  wire logic signed [CRD_W-1:0] in_pos_x,
  input  wire logic signed [CRD_W-1:0] in_pos_y,
  input  wire logic signed [CRD_W-1:0] in_pos_z,
  output logic                        out_valid,
  output logic                        out_found,
  output logic signed [CRD_W-1:0]     out_x,
  output logic signed [CRD_W-1:0]     out_y,
  output logic signed [CRD_W-1:0]     out_z,
  output logic [1:0]                  out_status,
  output logic [COUNT_OUT_W-1:0]      out_point_count,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  state_t               state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  point_t               q_r, q_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic [DRAIN_W-1:0]   drain_r, drain_nxt;
  crd_t                 ground_r;
  logic [THR_W-1:0]     dedupe_r;

  logic                 dup_r, dup_nxt;
  logic                 have_r, have_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [DIST_W-1:0]    best_d_r, best_d_nxt;
  point_t               best_pt_r, best_pt_nxt;
  logic                 match_r, match_nxt;
  logic [IDX_W-1:0]     match_idx_r, match_idx_nxt;

  logic                 out_valid_r, out_found_r, out_found_nxt;
  point_t               out_pt_r, out_pt_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [COUNT_OUT_W-1:0] out_count_r;

  logic                 rd_vld_r;
  logic [IDX_W-1:0]     rd_idx_r;
  scan_tag_t            dist_tag;
  scan_res_t            res;
  entry_t               rd_ent;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  entry_t               ram_wdata;

  logic                 accept, issue, finish, load_drain;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_idx_r == count_r || cmd_r == CMD_CLEAR) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drain_r == '0) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    issue      = 1'b0;
    load_drain = 1'b0;
    finish     = 1'b0;
    unique case (state_r)
      S_IDLE: ;
      S_SCAN: begin
        issue      = (scan_idx_r != count_r) && (cmd_r != CMD_CLEAR);
        load_drain = !issue;
      end
      S_DRAIN: ;
      S_FINISH: finish = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    cmd_nxt      = accept ? cmd_t'(in_cmd) : cmd_r;
    q_nxt        = q_r;
    scan_idx_nxt = scan_idx_r;
    drain_nxt    = drain_r;
    if (accept) begin
      q_nxt.x = in_pos_x;
      q_nxt.y = in_pos_y;
      q_nxt.z = (cmd_t'(in_cmd) == CMD_INSERT) ? sat_add(in_pos_z, ground_r) : in_pos_z;
      scan_idx_nxt = '0;
    end else if (issue) begin
      scan_idx_nxt = scan_idx_r + 1'b1;
    end
    if (load_drain) begin
      drain_nxt = DRAIN_W'(DRAIN_LEN - 1);
    end else if (state_r == S_DRAIN) begin
      drain_nxt = drain_r - 1'b1;
    end
  end

  nfpa_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_point_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(scan_idx_r[IDX_W-1:0]),
    .rdata(rd_ent)
  );

  assign dist_tag = '{vld: rd_vld_r, idx: rd_idx_r, tk: rd_ent.tk};

  nfpa_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .in_tag(dist_tag),
    .in_pt (rd_ent.pt),
    .query (q_r),
    .res   (res)
  );

  // Scan bookkeeping: duplicate flag, nearest free point, first exact match.
  always_comb begin
    dup_nxt       = dup_r;
    have_nxt      = have_r;
    best_idx_nxt  = best_idx_r;
    best_d_nxt    = best_d_r;
    best_pt_nxt   = best_pt_r;
    match_nxt     = match_r;
    match_idx_nxt = match_idx_r;
    if (accept) begin
      dup_nxt   = 1'b0;
      have_nxt  = 1'b0;
      match_nxt = 1'b0;
    end else if (res.tag.vld) begin
      if (cmd_r == CMD_INSERT && res.dsq < {{(DIST_W-THR_W){1'b0}}, dedupe_r}) begin
        dup_nxt = 1'b1;
      end
      if (cmd_r == CMD_CLAIM && !res.tag.tk && (!have_r || res.dsq < best_d_r)) begin
        have_nxt     = 1'b1;
        best_idx_nxt = res.tag.idx;
        best_d_nxt   = res.dsq;
        best_pt_nxt  = res.pt;
      end
      if (cmd_r == CMD_RELEASE && res.eq && !match_r) begin
        match_nxt     = 1'b1;
        match_idx_nxt = res.tag.idx;
      end
    end
  end

  // Write-back and result word.
  always_comb begin
    count_nxt      = count_r;
    ram_we         = 1'b0;
    ram_waddr      = count_r[IDX_W-1:0];
    ram_wdata      = '{tk: 1'b0, pt: q_r};
    out_found_nxt  = 1'b0;
    out_pt_nxt     = '0;
    out_status_nxt = STS_OK;
    if (finish) begin
      case (cmd_r)
        CMD_INSERT: begin
          if (dup_r) begin
            out_status_nxt = STS_DUP;
          end else if (count_r == CNT_W'(CAPACITY)) begin
            out_status_nxt = STS_FULL;
          end else begin
            ram_we    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_CLAIM: begin
          if (have_r) begin
            out_found_nxt = 1'b1;
            out_pt_nxt    = best_pt_r;
            ram_we        = 1'b1;
            ram_waddr     = best_idx_r;
            ram_wdata     = '{tk: 1'b1, pt: best_pt_r};
          end else begin
            out_status_nxt = STS_NONE;
          end
        end
        CMD_RELEASE: begin
          // The matched entry equals the query exactly, so the query goes back.
          if (match_r) begin
            out_found_nxt = 1'b1;
            ram_we        = 1'b1;
            ram_waddr     = match_idx_r;
          end else begin
            out_status_nxt = STS_NONE;
          end
        end
        default: begin
          count_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      ground_r    <= '0;
      dedupe_r    <= DEDUPE_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= issue;
      out_valid_r <= finish;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GROUND_OFFSET:  ground_r <= cfg_data[CRD_W-1:0];
          CFG_DEDUPE_DIST_SQ: dedupe_r <= cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    q_r          <= q_nxt;
    scan_idx_r   <= scan_idx_nxt;
    drain_r      <= drain_nxt;
    rd_idx_r     <= scan_idx_r[IDX_W-1:0];
    dup_r        <= dup_nxt;
    have_r       <= have_nxt;
    best_idx_r   <= best_idx_nxt;
    best_d_r     <= best_d_nxt;
    best_pt_r    <= best_pt_nxt;
    match_r      <= match_nxt;
    match_idx_r  <= match_idx_nxt;
    if (finish) begin
      out_found_r  <= out_found_nxt;
      out_pt_r     <= out_pt_nxt;
      out_status_r <= out_status_nxt;
      out_count_r  <= count_out(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_x           = out_pt_r.x;
  assign out_y           = out_pt_r.y;
  assign out_z           = out_pt_r.z;
  assign out_status      = out_status_r;
  assign out_point_count = out_count_r;

  // A result word only follows the write-back cycle.
  a_out_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_FINISH))
    else $error("result word without a write-back cycle");

  // The memory is only written in the write-back cycle and only within the table.
  a_write_in_finish: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_FINISH) && (CNT_W'(ram_waddr) < count_nxt))
    else $error("point memory written outside write-back or past the table");

  // The scan never reads beyond the stored points.
  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (scan_idx_r < count_r))
    else $error("scan read beyond stored points");

  // Distance results arrive only while the item is still in flight.
  a_res_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res.tag.vld |-> (state_r == S_SCAN) || (state_r == S_DRAIN))
    else $error("distance result outside scan");

  // A successful claim or release always reports status ok.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (out_status_r == STS_OK))
    else $error("found with a failure status");

endmodule

`default_nettype wire
